FILE: src/euler_to_quaternion_unit_assert.svh
// Assertion macros for the Euler-to-quaternion unit.
// Included by the checker; needs a clock aclk and an active-low reset aresetn.
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define E2Q_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/e2q_pkg.sv
// Shared types, constants and tables for the Euler-to-quaternion unit.
// Used by the lane, the merge stage and the top level; depends on nothing.
package e2q_pkg;

    localparam int ANGLE_W      = 17;
    localparam int RESULT_W     = 16;
    localparam int PHASE_W      = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int RECIP_DIV    = 45;
    localparam int LANE_LAT     = CORDIC_STEPS + 3;
    localparam int MERGE_LAT    = 3;
    localparam int LATENCY      = LANE_LAT + MERGE_LAT;

    localparam logic [16:0]        HALF_PERIOD = 17'd92160;
    localparam logic [16:0]        RECIP_MUL   = 17'd93207;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

    typedef logic [20:0] frac_tbl_t [64];

    localparam logic signed [31:0] ATAN_TBL [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    function automatic frac_tbl_t build_frac();
        frac_tbl_t t;
        for (int i = 0; i < 64; i++) begin
            if (i < RECIP_DIV) begin
                t[i] = 21'(((64'(i) << 21) + 64'd22) / 64'(RECIP_DIV));
            end else begin
                t[i] = '0;
            end
        end
        return t;
    endfunction

    localparam frac_tbl_t FRAC_TBL = build_frac();

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } trig_t;

endpackage

FILE: src/e2q_lane.sv
// One angle lane: half-angle phase reduction and a 24-stage CORDIC.
// Depends on e2q_pkg.
module e2q_lane (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    angle,
    output e2q_pkg::trig_t                        trig
);
    import e2q_pkg::*;

    logic [16:0]        r_reg;
    logic [16:0]        r1_reg;
    logic [33:0]        prod_reg;
    logic signed [17:0] angle_ext;
    logic [16:0]        r_next;
    logic [10:0]        q;
    logic [5:0]         m;
    logic [31:0]        phase;
    logic signed [31:0] z_next;
    logic               flip_next;

    logic signed [31:0] x_reg [CORDIC_STEPS+1];
    logic signed [31:0] y_reg [CORDIC_STEPS+1];
    logic signed [31:0] z_reg [CORDIC_STEPS+1];
    logic               flip_reg [CORDIC_STEPS+1];

    assign angle_ext = 18'(angle);
    assign r_next    = angle_ext < 0 ? 17'(angle_ext + 18'sd92160) : 17'(angle_ext);
    assign q         = prod_reg[32:22];
    assign m         = 6'(r1_reg - 17'(17'(q) * 17'd45));
    assign phase     = {q, FRAC_TBL[m]};
    assign flip_next = ($signed(phase) > 32'sd1073741824) ||
                       ($signed(phase) < -32'sd1073741824);
    assign z_next    = flip_next ? $signed({~phase[31], phase[30:0]}) : $signed(phase);

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg       <= r_next;
            r1_reg      <= r_reg;
            prod_reg    <= r_reg * RECIP_MUL;
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TBL[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TBL[i];
                end
            end
        end
    end

    assign trig.c = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign trig.s = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

endmodule

FILE: src/e2q_merge.sv
// Merge stage: triple products of the lane results, sums, rounding, saturation.
// Depends on e2q_pkg.
module e2q_merge (
    input  logic                                  aclk,
    input  logic                                  en,
    input  e2q_pkg::trig_t                        t1,
    input  e2q_pkg::trig_t                        t2,
    input  e2q_pkg::trig_t                        t3,
    output logic signed [e2q_pkg::RESULT_W-1:0]   quat_w,
    output logic signed [e2q_pkg::RESULT_W-1:0]   quat_x,
    output logic signed [e2q_pkg::RESULT_W-1:0]   quat_y,
    output logic signed [e2q_pkg::RESULT_W-1:0]   quat_z
);
    import e2q_pkg::*;

    logic signed [64:0] p_reg [4];
    logic signed [64:0] t_reg [8];
    logic signed [31:0] c3_reg;
    logic signed [31:0] s3_reg;
    logic signed [32:0] ab [4];
    logic signed [32:0] tri_q [8];
    logic signed [RESULT_W-1:0] q_next [4];
    logic signed [RESULT_W-1:0] q_reg  [4];

    function automatic logic signed [32:0] rnd30(input logic signed [64:0] p);
        logic signed [64:0] t;
        t = p + 65'sd536870912;
        return 33'(t >>> 30);
    endfunction

    function automatic logic signed [RESULT_W-1:0] to_q15(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd16384) >>> 15;
        if (t > 34'sd32767) begin
            return RESULT_W'(16'sd32767);
        end else if (t < -34'sd32768) begin
            return RESULT_W'(-16'sd32768);
        end
        return RESULT_W'(t);
    endfunction

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ab[k] = rnd30(p_reg[k]);
        end
        for (int k = 0; k < 8; k++) begin
            tri_q[k] = rnd30(t_reg[k]);
        end
        q_next[0] = to_q15(34'(tri_q[0]) - 34'(tri_q[1]));
        q_next[1] = to_q15(34'(tri_q[2]) + 34'(tri_q[3]));
        q_next[2] = to_q15(34'(tri_q[4]) - 34'(tri_q[5]));
        q_next[3] = to_q15(34'(tri_q[6]) + 34'(tri_q[7]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= t1.c * t2.c;
            p_reg[1] <= t1.s * t2.s;
            p_reg[2] <= t1.s * t2.c;
            p_reg[3] <= t1.c * t2.s;
            c3_reg   <= t3.c;
            s3_reg   <= t3.s;
            t_reg[0] <= ab[0] * c3_reg;
            t_reg[1] <= ab[1] * s3_reg;
            t_reg[2] <= ab[2] * c3_reg;
            t_reg[3] <= ab[3] * s3_reg;
            t_reg[4] <= ab[3] * c3_reg;
            t_reg[5] <= ab[2] * s3_reg;
            t_reg[6] <= ab[0] * s3_reg;
            t_reg[7] <= ab[1] * c3_reg;
            for (int k = 0; k < 4; k++) begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

endmodule

FILE: src/euler_to_quaternion_unit.sv
// Channel  Dir  Ports
// s_       in   s_valid, s_ready, s_angle_x, s_angle_y, s_angle_z
// m_       out  m_valid, m_ready, m_quat_w, m_quat_x, m_quat_y, m_quat_z
// One transaction per cycle unless m_ready stalls the output. Pipeline: 3 reduction
// and 24 CORDIC stages in each of three angle lanes, then 3 merge stages.
// The whole pipeline holds while the output register waits for m_ready.
// aresetn clears only the valid bits; no clearing pass.
// Top level; depends on e2q_pkg, e2q_lane and e2q_merge.
module euler_to_quaternion_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    s_angle_x,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    s_angle_y,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]    s_angle_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_w,
    output logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_x,
    output logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_y,
    output logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_z
);
    import e2q_pkg::*;

    logic               adv;
    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] valid_next;
    trig_t              trig_x;
    trig_t              trig_y;
    trig_t              trig_z;

    assign adv        = !valid_reg[LATENCY-1] || m_ready;
    assign s_ready    = adv;
    assign m_valid    = valid_reg[LATENCY-1];
    assign valid_next = {valid_reg[LATENCY-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    e2q_lane u_lane_x (.aclk(aclk), .en(adv), .angle(s_angle_x), .trig(trig_x));
    e2q_lane u_lane_y (.aclk(aclk), .en(adv), .angle(s_angle_y), .trig(trig_y));
    e2q_lane u_lane_z (.aclk(aclk), .en(adv), .angle(s_angle_z), .trig(trig_z));

    e2q_merge u_merge (
        .aclk   (aclk),
        .en     (adv),
        .t1     (trig_x),
        .t2     (trig_y),
        .t3     (trig_z),
        .quat_w (m_quat_w),
        .quat_x (m_quat_x),
        .quat_y (m_quat_y),
        .quat_z (m_quat_z)
    );

endmodule

FILE: src/e2q_checker.sv
// Port-level checks for euler_to_quaternion_unit, bound to the top level.
// Depends on e2q_pkg and euler_to_quaternion_unit_assert.svh.
`include "euler_to_quaternion_unit_assert.svh"

module e2q_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_w,
    input  logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_x,
    input  logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_y,
    input  logic signed [e2q_pkg::RESULT_W-1:0]   m_quat_z
);
    import e2q_pkg::*;

    logic [4*RESULT_W-1:0] m_payload;

    assign m_payload = {m_quat_w, m_quat_x, m_quat_y, m_quat_z};

    `E2Q_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `E2Q_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_payload), "stalled result changed")
    `E2Q_ASSERT(a_stall_blocks_in, m_valid && !m_ready |-> !s_ready, "input taken while stalled")
    `E2Q_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input blocked with no result held")
    `E2Q_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (.*);

FILE: test/tb_euler_to_quaternion_unit.sv
// Testbench for euler_to_quaternion_unit: drives angle triples, predicts the quaternion
// with a fixed-point CORDIC predictor and checks every result in order.
// Depends on e2q_pkg and the euler_to_quaternion_unit RTL.
`timescale 1ns / 1ps

class quat_scoreboard;
    typedef struct {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    quat_t pending[$];
    int errors;
    int checked;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void half_trig(longint a, output longint c, output longint s);
        longint period, r, z, x, y, dx, dy;
        longint unsigned ph;
        bit flip;
        period = 360 * 256;
        r = a % period;
        if (r < 0) r += period;
        ph = ((longint'(r) << 32) + period / 2) / period;
        ph &= 64'hFFFF_FFFF;
        z = longint'(ph);
        if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
        flip = 0;
        if (z > (longint'(1) << 30) || z < -(longint'(1) << 30)) begin
            z -= (longint'(1) << 31);
            if (z < -(longint'(1) << 31)) z += (longint'(1) << 32);
            flip = 1;
        end
        x = e2q_pkg::GAIN_Q30;
        y = 0;
        for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= e2q_pkg::ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += e2q_pkg::ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic longint triple(longint a, longint b, longint c);
        return round_shr(round_shr(a * b, 30) * c, 30);
    endfunction

    function automatic logic signed [15:0] to_q15(longint q30);
        longint v;
        v = round_shr(q30, 15);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function void note_angles(logic signed [16:0] ax, logic signed [16:0] ay,
                              logic signed [16:0] az);
        longint c1, s1, c2, s2, c3, s3;
        quat_t q;
        half_trig(ax, c1, s1);
        half_trig(ay, c2, s2);
        half_trig(az, c3, s3);
        q.w = to_q15(triple(c1, c2, c3) - triple(s1, s2, s3));
        q.x = to_q15(triple(s1, c2, c3) + triple(c1, s2, s3));
        q.y = to_q15(triple(c1, s2, c3) - triple(s1, c2, s3));
        q.z = to_q15(triple(c1, c2, s3) + triple(s1, s2, c3));
        pending.push_back(q);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_quat(logic signed [15:0] w, logic signed [15:0] x,
                    logic signed [15:0] y, logic signed [15:0] z);
        quat_t q;
        checked++;
        if (pending.size() == 0) begin
            report_mismatch("unexpected result, quat_w", w, 0);
            return;
        end
        q = pending.pop_front();
        if (w !== q.w) report_mismatch("quat_w", w, q.w);
        if (x !== q.x) report_mismatch("quat_x", x, q.x);
        if (y !== q.y) report_mismatch("quat_y", y, q.y);
        if (z !== q.z) report_mismatch("quat_z", z, q.z);
    endtask
endclass

module tb_euler_to_quaternion_unit;
    localparam int WATCHDOG = 5000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [16:0] s_angle_x = '0, s_angle_y = '0, s_angle_z = '0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;

    quat_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int stall_cycles = 0;
    int sent = 0;
    bit timed_out = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    euler_to_quaternion_unit dut (.*);

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_angles(s_angle_x, s_angle_y, s_angle_z);
        if (aresetn && m_valid && m_ready)
            sb.check_quat(m_quat_w, m_quat_x, m_quat_y, m_quat_z);
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_angles(logic signed [16:0] ax, logic signed [16:0] ay,
                               logic signed [16:0] az);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_angle_x <= ax;
        s_angle_y <= ay;
        s_angle_z <= az;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    function automatic logic signed [16:0] rand_angle();
        case ($urandom_range(9))
            0: return 17'($urandom);
            1: return 17'(($urandom_range(8) * 45 - 180) * 128);
            default: return 17'($signed($urandom_range(92160)) - 46080);
        endcase
    endfunction

    logic signed [16:0] corners[10] = '{
        -17'sd46080, 17'sd46080, 17'sd0, 17'sd23040, -17'sd23040,
        17'sd11520, -17'sd65536, 17'sd65535, 17'sd1, -17'sd1
    };

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        for (int i = 0; i < 10; i++) send_angles(corners[i], 0, 0);
        for (int i = 0; i < 10; i++) send_angles(0, corners[i], corners[9 - i]);
        send_angles(0, 0, 0);
        send_angles(17'sd46080, 17'sd46080, 17'sd46080);
        send_angles(17'sd23040, 17'sd11520, -17'sd46080);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 22 : (phase == 1) ? 64 : 0;
            recv_idle = (phase == 0) ? 64 : (phase == 1) ? 22 : 0;
            for (int i = 0; i < 134; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        $display("Sent %0d angle triples, checked %0d quaternions", sent, sb.checked);
        $display("Idle patterns: sender-heavy, receiver-heavy and back-to-back");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/e2q_pkg.sv
src/e2q_lane.sv
src/e2q_merge.sv
src/euler_to_quaternion_unit.sv
src/e2q_checker.sv
test/tb_euler_to_quaternion_unit.sv
